### rtl/dwps_pkg.sv
// Shared types, constants and helpers for the dual-wheel PI drive with line steering.
// Used by the drive modules in rtl/ but not by dwps_checker; depends on nothing else.
package dwps_pkg;

  // Full-scale duty, the hard ceiling on the drive limit
  localparam logic [12:0] DUTY_FULL = 13'd7200;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CFG_SPEED_KP  = 3'd0,
    CFG_SPEED_KI  = 3'd1,
    CFG_STEER_KP  = 3'd2,
    CFG_STEER_KD  = 3'd3,
    CFG_LEFT_TGT  = 3'd4,
    CFG_RIGHT_TGT = 3'd5,
    CFG_DRV_LIMIT = 3'd6
  } cfg_idx_t;

  // Register values after reset
  localparam logic [15:0] RST_SPEED_KP  = 16'd3072;
  localparam logic [15:0] RST_SPEED_KI  = 16'd3072;
  localparam logic [15:0] RST_STEER_KP  = 16'd4301;
  localparam logic [15:0] RST_STEER_KD  = 16'd1485;
  localparam logic [15:0] RST_LEFT_TGT  = 16'd10;
  localparam logic [15:0] RST_RIGHT_TGT = 16'd10;
  localparam logic [12:0] RST_DRV_LIMIT = 13'd6900;

  // Pipeline advance strobes: adv1 loads stage 1, adv2 loads the result stage
  typedef struct packed {
    logic adv1;
    logic adv2;
  } adv_t;

  // Clamp a signed drive to +/- lim, return {reverse, magnitude}
  function automatic logic [13:0] drive_clamp(logic signed [32:0] drive, logic [12:0] lim);
    logic signed [32:0] slim;
    logic signed [32:0] clip;
    logic               rev;
    logic [12:0]        mag;
    slim = $signed({20'd0, lim});
    if (drive > slim) begin
      clip = slim;
    end else if (drive < -slim) begin
      clip = -slim;
    end else begin
      clip = drive;
    end
    rev = clip[32];
    mag = rev ? 13'(-clip) : clip[12:0];
    return {rev, mag};
  endfunction

endpackage

### rtl/dwps_pi_wheel.sv
// Incremental PI speed loop for one wheel: error and increment stage, then
// saturating accumulator. Depends on dwps_pkg.
module dwps_pi_wheel (
  input  logic                clk,
  input  logic                rst_n,
  input  dwps_pkg::adv_t      adv,
  input  logic signed [15:0]  count,
  input  logic signed [15:0]  target,
  input  logic [15:0]         kp,
  input  logic [15:0]         ki,
  output logic signed [31:0]  accum_new
);

  logic signed [16:0] prev_err_r;
  logic signed [26:0] inc_r;
  logic signed [31:0] accum_r;

  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [34:0] prod_p;
  logic signed [34:0] prod_i;
  logic signed [34:0] sum;
  logic signed [34:0] rnd;
  logic signed [26:0] inc_nxt;
  logic signed [32:0] acc_sum;

  // Stage 1: error, PI increment, truncated toward zero
  always_comb begin
    err     = {count[15], count} - {target[15], target};
    diff    = {err[16], err} - {prev_err_r[16], prev_err_r};
    kp_s    = $signed({1'b0, kp});
    ki_s    = $signed({1'b0, ki});
    prod_p  = kp_s * diff;
    prod_i  = ki_s * err;
    sum     = prod_p + prod_i;
    rnd     = sum + (sum[34] ? 35'sd255 : 35'sd0);
    inc_nxt = 27'(rnd >>> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (adv.adv1) begin
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      inc_r <= inc_nxt;
    end
  end

  // Stage 2: accumulate with saturation at the 32-bit bounds
  always_comb begin
    acc_sum = {accum_r[31], accum_r} + {{6{inc_r[26]}}, inc_r};
    if (acc_sum[32] != acc_sum[31]) begin
      accum_new = acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      accum_new = acc_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (adv.adv2) begin
      accum_r <= accum_new;
    end
  end

endmodule

### rtl/dwps_steer.sv
// PD line steering term from the line offset about the image centre.
// Depends on dwps_pkg.
module dwps_steer #(
  parameter int IMAGE_WIDTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dwps_pkg::adv_t      adv,
  input  logic [7:0]          center,
  input  logic [15:0]         kp,
  input  logic [15:0]         kd,
  output logic signed [18:0]  steer_r
);

  localparam logic [8:0] HALF_OFF = 9'(IMAGE_WIDTH / 2);

  logic signed [8:0]  prev_off_r;
  logic signed [8:0]  off;
  logic signed [9:0]  doff;
  logic signed [16:0] kp_s;
  logic signed [16:0] kd_s;
  logic signed [26:0] prod_p;
  logic signed [26:0] prod_d;
  logic signed [26:0] sum;
  logic signed [26:0] rnd;
  logic signed [18:0] steer_nxt;

  // Offset, derivative and scaled PD sum, truncated toward zero
  always_comb begin
    off       = $signed({1'b0, center} - HALF_OFF);
    doff      = {off[8], off} - {prev_off_r[8], prev_off_r};
    kp_s      = $signed({1'b0, kp});
    kd_s      = $signed({1'b0, kd});
    prod_p    = kp_s * off;
    prod_d    = kd_s * doff;
    sum       = prod_p + prod_d;
    rnd       = sum + (sum[26] ? 27'sd255 : 27'sd0);
    steer_nxt = 19'(rnd >>> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_off_r <= '0;
    end else if (adv.adv1) begin
      prev_off_r <= off;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      steer_r <= steer_nxt;
    end
  end

endmodule

### rtl/dual_wheel_pi_with_line_steer_core.sv
// Dual-wheel incremental PI speed control with PD line steering, three-stage pipeline.
// Items pass from the input register through stage 1 to the result register on out_*.
// Throughput: one item per cycle while out_stall is low; stalled, earlier stages still fill.
// Reset (rst_n low, synchronous) clears accumulators, previous errors and offset, and
// returns every configuration register to its default. Depends on dwps_pkg, dwps_pi_wheel,
// dwps_steer.
module dual_wheel_pi_with_line_steer_core #(
  parameter int IMAGE_WIDTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic [7:0]         in_line_center,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        out_left_magnitude,
  output logic               out_left_reverse,
  output logic [12:0]        out_right_magnitude,
  output logic               out_right_reverse,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  // configuration registers
  logic [15:0]        speed_kp_r;
  logic [15:0]        speed_ki_r;
  logic [15:0]        steer_kp_r;
  logic [15:0]        steer_kd_r;
  logic signed [15:0] left_tgt_r;
  logic signed [15:0] right_tgt_r;
  logic [12:0]        drv_limit_r;

  // pipeline
  logic               v0_r;
  logic               v1_r;
  logic               out_valid_r;
  logic signed [15:0] lc_r;
  logic signed [15:0] rc_r;
  logic [7:0]         center_r;
  logic               en0;
  logic               en1;
  logic               en2;
  dwps_pkg::adv_t     adv;

  logic signed [31:0] left_acc;
  logic signed [31:0] right_acc;
  logic signed [18:0] steer_r;
  logic [12:0]        lim;
  logic signed [32:0] left_drive;
  logic signed [32:0] right_drive;
  logic [13:0]        left_cl;
  logic [13:0]        right_cl;
  logic [12:0]        left_mag_r;
  logic               left_rev_r;
  logic [12:0]        right_mag_r;
  logic               right_rev_r;

  // Configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r  <= dwps_pkg::RST_SPEED_KP;
      speed_ki_r  <= dwps_pkg::RST_SPEED_KI;
      steer_kp_r  <= dwps_pkg::RST_STEER_KP;
      steer_kd_r  <= dwps_pkg::RST_STEER_KD;
      left_tgt_r  <= dwps_pkg::RST_LEFT_TGT;
      right_tgt_r <= dwps_pkg::RST_RIGHT_TGT;
      drv_limit_r <= dwps_pkg::RST_DRV_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dwps_pkg::cfg_idx_t'(cfg_index))
        dwps_pkg::CFG_SPEED_KP:  speed_kp_r  <= cfg_wdata;
        dwps_pkg::CFG_SPEED_KI:  speed_ki_r  <= cfg_wdata;
        dwps_pkg::CFG_STEER_KP:  steer_kp_r  <= cfg_wdata;
        dwps_pkg::CFG_STEER_KD:  steer_kd_r  <= cfg_wdata;
        dwps_pkg::CFG_LEFT_TGT:  left_tgt_r  <= cfg_wdata;
        dwps_pkg::CFG_RIGHT_TGT: right_tgt_r <= cfg_wdata;
        dwps_pkg::CFG_DRV_LIMIT: drv_limit_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on
  always_comb begin
    en2      = !out_valid_r || !out_stall;
    en1      = !v1_r || en2;
    en0      = !v0_r || en1;
    in_stall = !en0;
    adv.adv1 = v0_r && en1;
    adv.adv2 = v1_r && en2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) out_valid_r <= v1_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      lc_r     <= in_left_count;
      rc_r     <= in_right_count;
      center_r <= in_line_center;
    end
  end

  // Per-wheel PI loops and the shared steering term
  dwps_pi_wheel u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .count     (lc_r),
    .target    (left_tgt_r),
    .kp        (speed_kp_r),
    .ki        (speed_ki_r),
    .accum_new (left_acc)
  );

  dwps_pi_wheel u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .count     (rc_r),
    .target    (right_tgt_r),
    .kp        (speed_kp_r),
    .ki        (speed_ki_r),
    .accum_new (right_acc)
  );

  dwps_steer #(
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_steer (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .center  (center_r),
    .kp      (steer_kp_r),
    .kd      (steer_kd_r),
    .steer_r (steer_r)
  );

  // Mix steering into each drive and clamp
  always_comb begin
    lim         = (drv_limit_r > dwps_pkg::DUTY_FULL) ? dwps_pkg::DUTY_FULL : drv_limit_r;
    left_drive  = {left_acc[31], left_acc} - {{14{steer_r[18]}}, steer_r};
    right_drive = {right_acc[31], right_acc} + {{14{steer_r[18]}}, steer_r};
    left_cl     = dwps_pkg::drive_clamp(left_drive, lim);
    right_cl    = dwps_pkg::drive_clamp(right_drive, lim);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv.adv2) begin
      left_mag_r  <= left_cl[12:0];
      left_rev_r  <= left_cl[13];
      right_mag_r <= right_cl[12:0];
      right_rev_r <= right_cl[13];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_magnitude  = left_mag_r;
  assign out_left_reverse    = left_rev_r;
  assign out_right_magnitude = right_mag_r;
  assign out_right_reverse   = right_rev_r;

endmodule

### rtl/dwps_checker.sv
// Port-level checks on the drive core's result channel, bound to the top level.
// Depends on dual_wheel_pi_with_line_steer_core.
module dwps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_left_magnitude,
  input logic        out_left_reverse,
  input logic [12:0] out_right_magnitude,
  input logic        out_right_reverse
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_magnitude) && $stable(out_left_reverse)
      && $stable(out_right_magnitude) && $stable(out_right_reverse))
    else $error("result item changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // Clamp never exceeds full-scale duty
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_magnitude <= 13'd7200 && out_right_magnitude <= 13'd7200)
    else $error("drive magnitude above full scale");

  // A zero drive is never flagged as reverse
  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_left_reverse || out_left_magnitude != 13'd0)
      && (!out_right_reverse || out_right_magnitude != 13'd0))
    else $error("reverse flag set on a zero drive");

endmodule

bind dual_wheel_pi_with_line_steer_core dwps_checker u_dwps_checker (.*);
